// ===== rtl/core/ptsnap_pkg.sv =====
// Shared constants, tick tables and types for the price tick snapper.
package ptsnap_pkg;

   // raw price units per yen
   localparam longint unsigned PRICE_SCALE = 10000;

   localparam int PRICE_W     = 40;
   localparam int SEL_W       = 2;
   localparam int STEP_OUT_W  = 29;
   localparam int REQ_DATA_W  = 40;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_PAD_W   = RSP_DATA_W - PRICE_W - STEP_OUT_W;
   localparam int BOUND_W     = 64;

   localparam int N_TABLES    = 3;
   localparam int N_BRACKETS  = 10;
   localparam int TBL_IDX_W   = $clog2(N_TABLES);

   // selector codes on the request side
   localparam logic [SEL_W-1:0] SEL_INDEX = 2'd1;
   localparam logic [SEL_W-1:0] SEL_FUND  = 2'd2;

   // table slots
   localparam logic [TBL_IDX_W-1:0] TBL_GENERAL = 2'd0;
   localparam logic [TBL_IDX_W-1:0] TBL_INDEX   = 2'd1;
   localparam logic [TBL_IDX_W-1:0] TBL_FUND    = 2'd2;

   // bracket upper bounds in yen; fund table padded with its last row
   localparam longint unsigned BRACKET_TOP [N_TABLES][N_BRACKETS] = '{
      '{3000, 5000, 30000, 50000, 300000, 500000, 3000000, 5000000,
        30000000, 50000000},
      '{1000, 3000, 10000, 30000, 100000, 300000, 1000000, 3000000,
        10000000, 30000000},
      '{10000, 30000, 100000, 300000, 1000000, 3000000, 10000000,
        30000000, 30000000, 30000000}
   };

   // tick sizes in tenths of a yen
   localparam longint unsigned TICK_TENTHS [N_TABLES][N_BRACKETS] = '{
      '{10, 50, 100, 500, 1000, 5000, 10000, 50000, 100000, 500000},
      '{1, 5, 10, 50, 100, 500, 1000, 5000, 10000, 50000},
      '{10, 50, 100, 500, 1000, 5000, 10000, 50000, 50000, 50000}
   };

   localparam longint unsigned MAX_TICK_TENTHS = 500000;
   localparam longint unsigned MAX_STEP = (MAX_TICK_TENTHS * PRICE_SCALE + 5) / 10;
   localparam int STEP_W = $clog2(MAX_STEP + 1);
   localparam longint unsigned STEP_OUT_MAX = (64'd1 << STEP_OUT_W) - 1;

   // dividend is price plus half a step
   localparam int X_W        = PRICE_W + 1;
   localparam int DIG_W      = 4;
   localparam int DIV_STAGES = (X_W + DIG_W - 1) / DIG_W;
   localparam int XPAD_W     = DIV_STAGES * DIG_W;

   typedef logic [PRICE_W-1:0] price_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [X_W-1:0]     xval_type;

   // tick in tenths to raw step, rounded half-up, at least one
   function automatic step_type step_of(input longint unsigned tick);
      longint unsigned s;
      s = (tick * PRICE_SCALE + 5) / 10;
      if (s == 0) begin
         s = 1;
      end
      return STEP_W'(s);
   endfunction

endpackage

// ===== rtl/core/ptsnap_bracket.sv =====
// Bracket lookup: picks the tick step for a price in the selected table.
module ptsnap_bracket import ptsnap_pkg::*; (
   input  price_type              price,
   input  logic [SEL_W-1:0]       sel,
   output step_type               step
);

   logic [BOUND_W-1:0] bnd_tab  [N_TABLES][N_BRACKETS];
   step_type           step_tab [N_TABLES][N_BRACKETS];

   for (genvar t = 0; t < N_TABLES; t++) begin : g_tbl
      for (genvar i = 0; i < N_BRACKETS; i++) begin : g_row
         assign bnd_tab[t][i]  = BOUND_W'(BRACKET_TOP[t][i] * PRICE_SCALE);
         assign step_tab[t][i] = step_of(TICK_TENTHS[t][i]);
      end
   end

   always_comb begin
      logic [TBL_IDX_W-1:0] tbl;
      logic [BOUND_W-1:0]   price_ext;
      unique case (sel)
         SEL_INDEX: tbl = TBL_INDEX;
         SEL_FUND:  tbl = TBL_FUND;
         default:   tbl = TBL_GENERAL;
      endcase
      price_ext = BOUND_W'(price);
      // last row is the fallback above the top bound; scan down so the lowest matching row wins
      step = step_tab[tbl][N_BRACKETS-1];
      for (int i = N_BRACKETS - 1; i >= 0; i--) begin
         if (price_ext <= bnd_tab[tbl][i]) begin
            step = step_tab[tbl][i];
         end
      end
   end

endmodule

// ===== rtl/core/ptsnap_div_step.sv =====
// Restoring remainder step: folds DIG_W dividend bits into a running remainder.
module ptsnap_div_step import ptsnap_pkg::*; (
   input  step_type             rem_in,
   input  logic [DIG_W-1:0]     digits,
   input  step_type             divisor,
   output step_type             rem_out
);

   always_comb begin
      logic [STEP_W:0] acc;
      step_type        r;
      r = rem_in;
      for (int i = DIG_W - 1; i >= 0; i--) begin
         acc = {r, digits[i]};
         if (acc >= {1'b0, divisor}) begin
            acc = acc - {1'b0, divisor};
         end
         r = acc[STEP_W-1:0];
      end
      rem_out = r;
   end

endmodule

// ===== rtl/core/price_tick_snap.sv =====
// Top level of the price tick snapper: lookup, remainder pipeline, output register.
//
// Takes one raw price (1/PRICE_SCALE yen units) plus a tick table selector per
// request and returns the tick step of the matching price bracket together with
// the price rounded half-up onto that tick grid, saturated to 40 bits; the step
// saturates at the 29-bit field maximum. A new request is taken every cycle unless
// rsp_tready back-pressure has filled the pipeline. Requests pass through the
// bracket compare register, the half-step add register, one remainder register
// per four bits of the default 41-bit dividend, and the output register. Each stage
// has its own valid bit and moves whenever the stage after it is empty or
// moving, so bubbles close up and requests keep entering while a result waits.
module price_tick_snap import ptsnap_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [39:0] price_in
   input  logic [REQ_USER_W-1:0]  req_tuser,   // [1:0] table_select
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata    // [39:0] price_snapped, [68:40] tick_step
);

   // stage 0: bracket lookup result
   logic       s0_vld_ff;
   price_type  s0_price_ff;
   step_type   s0_step_ff;
   step_type   lk_step_in;

   // stage 1: dividend = price + step/2
   logic       s1_vld_ff;
   xval_type   s1_x_ff;
   step_type   s1_step_ff;
   xval_type   s1_x_in;

   // remainder pipeline
   logic [DIV_STAGES-1:0] dv_vld_ff;
   xval_type   dv_x_ff   [DIV_STAGES];
   step_type   dv_rem_ff [DIV_STAGES];
   step_type   dv_stp_ff [DIV_STAGES];
   step_type   dv_rem_in [DIV_STAGES];

   // output register
   logic                   out_vld_ff;
   price_type              out_snap_ff;
   logic [STEP_OUT_W-1:0]  out_tick_ff;
   price_type              out_snap_in;
   logic [STEP_OUT_W-1:0]  out_tick_in;
   xval_type               snap_full;

   // per-stage move enables
   logic                   s0_rdy;
   logic                   s1_rdy;
   logic [DIV_STAGES-1:0]  dv_rdy;
   logic                   out_rdy;

   always_comb begin
      out_rdy = !out_vld_ff || rsp_tready;
      dv_rdy[DIV_STAGES-1] = !dv_vld_ff[DIV_STAGES-1] || out_rdy;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         dv_rdy[k] = !dv_vld_ff[k] || dv_rdy[k+1];
      end
      s1_rdy = !s1_vld_ff || dv_rdy[0];
      s0_rdy = !s0_vld_ff || s1_rdy;
   end

   assign req_tready = s0_rdy;

   // ---- stage 0: bracket compare ----
   ptsnap_bracket u_bracket (
      .price (req_tdata[PRICE_W-1:0]),
      .sel   (req_tuser[SEL_W-1:0]),
      .step  (lk_step_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_vld_ff <= req_tvalid;
      end
      if (s0_rdy && req_tvalid) begin
         s0_price_ff <= req_tdata[PRICE_W-1:0];
         s0_step_ff  <= lk_step_in;
      end
   end

   // ---- stage 1: add half a step for round half-up ----
   assign s1_x_in = X_W'(s0_price_ff) + X_W'(s0_step_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_vld_ff <= s0_vld_ff;
      end
      if (s1_rdy && s0_vld_ff) begin
         s1_x_ff    <= s1_x_in;
         s1_step_ff <= s0_step_ff;
      end
   end

   // ---- remainder pipeline, MSB digits first ----
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic               src_vld;
      xval_type           src_x;
      step_type           src_rem;
      step_type           src_stp;
      logic [XPAD_W-1:0]  src_xpad;

      if (k == 0) begin : g_first
         assign src_vld = s1_vld_ff;
         assign src_x   = s1_x_ff;
         assign src_rem = '0;
         assign src_stp = s1_step_ff;
      end else begin : g_next
         assign src_vld = dv_vld_ff[k-1];
         assign src_x   = dv_x_ff[k-1];
         assign src_rem = dv_rem_ff[k-1];
         assign src_stp = dv_stp_ff[k-1];
      end

      assign src_xpad = XPAD_W'(src_x);

      ptsnap_div_step u_step (
         .rem_in  (src_rem),
         .digits  (src_xpad[XPAD_W-1-k*DIG_W -: DIG_W]),
         .divisor (src_stp),
         .rem_out (dv_rem_in[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (dv_rdy[k]) begin
            dv_vld_ff[k] <= src_vld;
         end
         if (dv_rdy[k] && src_vld) begin
            dv_x_ff[k]   <= src_x;
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_stp_ff[k] <= src_stp;
         end
      end
   end

   // ---- output: snapped = dividend - remainder, then saturate ----
   assign snap_full   = dv_x_ff[DIV_STAGES-1] - X_W'(dv_rem_ff[DIV_STAGES-1]);
   assign out_snap_in = snap_full[X_W-1] ? '1 : snap_full[PRICE_W-1:0];
   assign out_tick_in = (BOUND_W'(dv_stp_ff[DIV_STAGES-1]) > BOUND_W'(STEP_OUT_MAX)) ?
                        '1 : STEP_OUT_W'(dv_stp_ff[DIV_STAGES-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         out_vld_ff <= dv_vld_ff[DIV_STAGES-1];
      end
      if (out_rdy && dv_vld_ff[DIV_STAGES-1]) begin
         out_snap_ff <= out_snap_in;
         out_tick_ff <= out_tick_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_tick_ff, out_snap_ff};

   // ---- checks ----
   // an accepted request always lands in stage 0
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s0_vld_ff)
      else $error("accepted request did not enter stage 0");

   // lookup never yields a zero step
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      s0_vld_ff |-> (s0_step_ff != '0))
      else $error("zero tick step in stage 0");

   // final remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[DIV_STAGES-1] |-> (dv_rem_ff[DIV_STAGES-1] < dv_stp_ff[DIV_STAGES-1]))
      else $error("remainder not below tick step");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_tvalid && !s0_vld_ff && (dv_vld_ff == '0)))
      else $error("pipeline not empty after reset");

endmodule

// ===== bench/price_tick_snap_tb.sv =====
// Self-checking testbench for price_tick_snap: directed rows, then random requests.
`timescale 1ns / 1ps

module price_tick_snap_tb;
   import ptsnap_pkg::*;

   // general table answers to both of these selector codes
   localparam logic [SEL_W-1:0] SEL_GENERAL     = 2'd0;
   localparam logic [SEL_W-1:0] SEL_GENERAL_ALT = 2'd3;

   localparam longint unsigned PRICE_MAX      = (64'd1 << PRICE_W) - 1;
   localparam longint unsigned STEP_FIELD_MAX = (64'd1 << STEP_OUT_W) - 1;

   localparam int MAX_GAP       = 10;
   localparam int HOLD_CYCLES   = 200;   // long output hold-off, fills the pipeline
   localparam int DRAIN_CYCLES  = 32;    // covers the block's pipeline, plus margin
   localparam int IDLE_LIMIT    = 2000;  // cycles with no request or response moving
   localparam int MAX_REPORTS   = 40;

   // Bracket tables, slot order general / index / fund.
   // Upper bounds in yen, ticks in tenths of a yen.
   localparam longint unsigned BRK_UPPER [3][10] = '{
      '{3000, 5000, 30000, 50000, 300000, 500000, 3000000, 5000000,
        30000000, 50000000},
      '{1000, 3000, 10000, 30000, 100000, 300000, 1000000, 3000000,
        10000000, 30000000},
      '{10000, 30000, 100000, 300000, 1000000, 3000000, 10000000,
        30000000, 0, 0}
   };
   localparam longint unsigned BRK_TICK [3][10] = '{
      '{10, 50, 100, 500, 1000, 5000, 10000, 50000, 100000, 500000},
      '{1, 5, 10, 50, 100, 500, 1000, 5000, 10000, 50000},
      '{10, 50, 100, 500, 1000, 5000, 10000, 50000, 0, 0}
   };
   localparam int BRK_COUNT [3] = '{10, 10, 8};

   typedef struct packed {
      logic [PRICE_W-1:0]    snapped;
      logic [STEP_OUT_W-1:0] step;
   } snap_result_type;

   // one directed request; typed = expected values given in the row
   typedef struct packed {
      price_type             price;
      logic [SEL_W-1:0]      sel;
      logic                  typed;
      logic [PRICE_W-1:0]    snapped;
      logic [STEP_OUT_W-1:0] step;
   } snap_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [39:0] price_in
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [1:0] table_select
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [39:0] price_snapped, [68:40] tick_step

   snap_result_type pending_snaps [$];

   int  error_count     = 0;
   int  requests_sent   = 0;
   int  results_checked = 0;
   int  idle_cycles     = 0;
   bit  burst_mode      = 1'b0;  // both sides at full rate
   bit  hold_rsp        = 1'b0;  // ask the receiver for one long hold-off

   // Extremes, bracket edges and half-tick rounding; zeros in the last two
   // columns of an untyped row mean the predictor supplies the values.
   snap_row_type directed_rows [23] = '{
      '{40'd0, SEL_GENERAL, 1'b1, 40'd0, 29'd10000},
      '{40'd0, SEL_INDEX, 1'b1, 40'd0, 29'd1000},
      '{40'd0, SEL_FUND, 1'b1, 40'd0, 29'd10000},
      '{40'd0, SEL_GENERAL_ALT, 1'b1, 40'd0, 29'd10000},
      '{40'hFF_FFFF_FFFF, SEL_GENERAL, 1'b1, 40'd1099500000000, 29'd500000000},
      '{40'hFF_FFFF_FFFF, SEL_INDEX, 1'b1, 40'd1099500000000, 29'd50000000},
      '{40'hFF_FFFF_FFFF, SEL_FUND, 1'b1, 40'd1099500000000, 29'd50000000},
      '{40'hFF_FFFF_FFFF, SEL_GENERAL_ALT, 1'b1, 40'd1099500000000, 29'd500000000},
      // exactly half a tick rounds up, one below rounds down
      '{40'd1500, SEL_INDEX, 1'b1, 40'd2000, 29'd1000},
      '{40'd1499, SEL_INDEX, 1'b1, 40'd1000, 29'd1000},
      '{40'd5000, SEL_GENERAL, 1'b1, 40'd10000, 29'd10000},
      '{40'd4999, SEL_GENERAL, 1'b1, 40'd0, 29'd10000},
      // price on a bound stays in that bracket
      '{40'd10000000, SEL_INDEX, 1'b1, 40'd10000000, 29'd1000},
      '{40'd10000001, SEL_INDEX, 1'b0, 40'd0, 29'd0},
      '{40'd30000000, SEL_GENERAL, 1'b0, 40'd0, 29'd0},
      '{40'd30000001, SEL_GENERAL_ALT, 1'b0, 40'd0, 29'd0},
      // at and past the last bound of the general and index tables, past it for fund
      '{40'd500000000000, SEL_GENERAL, 1'b0, 40'd0, 29'd0},
      '{40'd500000000001, SEL_GENERAL, 1'b0, 40'd0, 29'd0},
      '{40'd300000000000, SEL_INDEX, 1'b0, 40'd0, 29'd0},
      '{40'd300000000001, SEL_INDEX, 1'b0, 40'd0, 29'd0},
      '{40'd300000000001, SEL_FUND, 1'b0, 40'd0, 29'd0},
      // alternating bit patterns
      '{40'h55_5555_5555, SEL_GENERAL_ALT, 1'b0, 40'd0, 29'd0},
      '{40'hAA_AAAA_AAAA, SEL_INDEX, 1'b0, 40'd0, 29'd0}
   };

   price_tick_snap u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int table_of(input logic [SEL_W-1:0] sel);
      if (sel == SEL_INDEX) begin
         return int'(TBL_INDEX);
      end
      if (sel == SEL_FUND) begin
         return int'(TBL_FUND);
      end
      return int'(TBL_GENERAL);
   endfunction

   // Tick lookup and half-up snap for one request.
   function automatic snap_result_type snap_to_tick(input price_type price,
                                                    input logic [SEL_W-1:0] sel);
      int t;
      int i;
      longint unsigned p;
      longint unsigned tick;
      longint unsigned step;
      longint unsigned snapped;
      snap_result_type r;
      t = table_of(sel);
      p = longint'(price);
      // past the last bound the last tick holds
      tick = BRK_TICK[t][BRK_COUNT[t] - 1];
      // walk down so the lowest matching bracket wins
      for (i = BRK_COUNT[t] - 1; i >= 0; i--) begin
         if (p <= BRK_UPPER[t][i] * PRICE_SCALE) begin
            tick = BRK_TICK[t][i];
         end
      end
      step = (tick * PRICE_SCALE + 5) / 10;
      if (step == 0) begin
         step = 1;
      end
      snapped = ((p + step / 2) / step) * step;
      if (snapped > PRICE_MAX) begin
         snapped = PRICE_MAX;
      end
      r.snapped = snapped[PRICE_W-1:0];
      r.step    = (step > STEP_FIELD_MAX) ? STEP_FIELD_MAX[STEP_OUT_W-1:0]
                                          : step[STEP_OUT_W-1:0];
      return r;
   endfunction

   // Random price aimed at the interesting spots of the chosen table:
   // full range, bracket edges, half-tick points, and small values.
   function automatic price_type pick_price(input logic [SEL_W-1:0] sel);
      int t;
      int i;
      int mode;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned tick;
      longint unsigned step;
      longint unsigned p;
      t    = table_of(sel);
      mode = $urandom_range(0, 9);
      if (mode <= 2) begin
         p = {$urandom, $urandom} & PRICE_MAX;
      end else if (mode <= 5) begin
         i = $urandom_range(0, BRK_COUNT[t] - 1);
         p = BRK_UPPER[t][i] * PRICE_SCALE - 2 + $urandom_range(0, 4);
      end else if (mode <= 8) begin
         // i == count picks the region above the last bound
         i    = $urandom_range(0, BRK_COUNT[t]);
         lo   = (i == 0) ? 0 : BRK_UPPER[t][i-1] * PRICE_SCALE;
         hi   = (i == BRK_COUNT[t]) ? PRICE_MAX : BRK_UPPER[t][i] * PRICE_SCALE;
         tick = BRK_TICK[t][(i == BRK_COUNT[t]) ? i - 1 : i];
         step = (tick * PRICE_SCALE + 5) / 10;
         if (step == 0) begin
            step = 1;
         end
         p = lo + ({$urandom, $urandom} % (hi - lo + 1));
         p = (p / step) * step + step / 2 + $urandom_range(0, 2);
         if (p > 0) begin
            p = p - 1;
         end
      end else begin
         p = $urandom_range(0, 20000);
      end
      if (p > PRICE_MAX) begin
         p = PRICE_MAX;
      end
      return p[PRICE_W-1:0];
   endfunction

   // Offer one request after a random gap and hold it until taken.
   task automatic send_request(input snap_row_type row);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.price;
      req_tuser  <= row.sel;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (row.typed) begin
         pending_snaps.push_back(snap_result_type'{row.snapped, row.step});
      end else begin
         pending_snaps.push_back(snap_to_tick(row.price, row.sel));
      end
   endtask

   task automatic send_random(input int n);
      snap_row_type row;
      repeat (n) begin
         row.sel     = $urandom_range(0, 3);
         row.price   = pick_price(row.sel);
         row.typed   = 1'b0;
         row.snapped = '0;
         row.step    = '0;
         send_request(row);
      end
   endtask

   task automatic wait_all_results();
      while (pending_snaps.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, one long hold-off on demand.
   initial begin : rsp_drive
      int stall;
      @(posedge clock iff !reset);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_rsp) begin
            stall    = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Response check against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      snap_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_snaps.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: unexpected response, actual tdata=%h", $time, rsp_tdata);
            end
         end else begin
            want = pending_snaps.pop_front();
            results_checked++;
            if (rsp_tdata[PRICE_W-1:0] !== want.snapped) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: price_snapped expected %0d actual %0d", $time,
                           want.snapped, rsp_tdata[PRICE_W-1:0]);
               end
            end
            if (rsp_tdata[PRICE_W +: STEP_OUT_W] !== want.step) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: tick_step expected %0d actual %0d", $time,
                           want.step, rsp_tdata[PRICE_W +: STEP_OUT_W]);
               end
            end
         end
      end
   end

   // Watchdog: nothing moving on either side for too long ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time,
                     IDLE_LIMIT);
            $display("FAIL price_tick_snap");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_request(directed_rows[r]);
      end

      send_random(150);

      // output held off for a long stretch while requests keep coming
      hold_rsp = 1'b1;
      burst_mode = 1'b1;
      send_random(40);
      burst_mode = 1'b0;

      // sender pause until the pipeline is empty, then full rate both ways
      req_tvalid <= 1'b0;
      wait_all_results();
      burst_mode = 1'b1;
      send_random(100);
      burst_mode = 1'b0;

      send_random(160);
      req_tvalid <= 1'b0;

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests over all selector codes and %0d responses checked,",
               requests_sent, results_checked);
      $display("with bracket edges, half-tick rounding, a long stall and full-rate bursts.");
      if (error_count == 0) begin
         $display("PASS price_tick_snap");
      end else begin
         $display("FAIL price_tick_snap");
      end
      $finish;
   end

endmodule
